FILE: hdl/av1_temporal_unit_splitter_macros.svh
// Assertion macros for the AV1 temporal unit splitter checker.
// No dependencies; included by the checker file only.
`ifndef AV1_TEMPORAL_UNIT_SPLITTER_MACROS_SVH
`define AV1_TEMPORAL_UNIT_SPLITTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AV1TUS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define AV1TUS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/av1tus_pkg.sv
// Shared types and constants for the AV1 temporal unit splitter.
// No dependencies.
package av1tus_pkg;

    localparam logic [3:0] OBU_TYPE_TD            = 4'd2;  // temporal delimiter OBU type
    localparam int         LEB_BITS               = 7;   // payload bits per LEB128 byte
    localparam int         COUNT_OUT_W            = 32;  // unit_count field width

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_EXT     = 3'd1,
        PH_SIZE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_HALTED  = 3'd4
    } t_phase;

    typedef struct packed {
        logic                   unit_start;
        logic                   header_byte;
        logic [3:0]             obu_type;
        logic                   halted;
        logic                   truncated;
        logic [COUNT_OUT_W-1:0] unit_count;
    } t_result;

endpackage

FILE: hdl/av1tus_parser.sv
// OBU header walker: parser state registers and the per-byte result logic.
// Depends on av1tus_pkg.
module av1tus_parser #(
    parameter int MAX_SIZE_BYTES   = 8,
    parameter int UNIT_COUNT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output av1tus_pkg::t_result o_result
);
    import av1tus_pkg::*;

    localparam int ACC_W = LEB_BITS * MAX_SIZE_BYTES;
    localparam int IDX_W = (MAX_SIZE_BYTES > 1) ? $clog2(MAX_SIZE_BYTES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SIZE_BYTES - 1);

    t_phase                      r_phase,    n_phase;
    logic [3:0]                  r_type,     n_type;
    logic [ACC_W-1:0]            r_acc,      n_acc;
    logic [IDX_W-1:0]            r_idx,      n_idx;
    logic [ACC_W-1:0]            r_rem,      n_rem;
    logic                        r_at_start;
    logic [UNIT_COUNT_WIDTH-1:0] r_count,    n_count;

    logic                   is_header;
    logic                   td_start;
    logic [ACC_W-1:0]       lane_bits;
    logic [ACC_W-1:0]       acc_step;
    logic [ACC_W-1:0]       rem_dec;
    logic [COUNT_OUT_W-1:0] count_out;

    // next state of the parser for this byte
    always_comb begin
        n_phase   = r_phase;
        n_type    = r_type;
        n_acc     = r_acc;
        n_idx     = r_idx;
        n_rem     = r_rem;
        is_header = 1'b0;
        td_start  = 1'b0;
        lane_bits = '0;
        for (int k = 0; k < MAX_SIZE_BYTES; k++) begin
            if (r_idx == IDX_W'(k)) begin
                lane_bits[k*LEB_BITS +: LEB_BITS] = i_data_byte[LEB_BITS-1:0];
            end
        end
        acc_step = r_acc | lane_bits;
        rem_dec  = r_rem - ACC_W'(r_rem != '0);

        case (r_phase)
            PH_HEADER: begin
                is_header = 1'b1;
                n_type    = i_data_byte[6:3];
                if (!i_data_byte[1]) begin
                    n_phase = PH_HALTED;
                end else begin
                    td_start = !r_at_start && (i_data_byte[6:3] == OBU_TYPE_TD);
                    n_acc    = '0;
                    n_idx    = '0;
                    n_phase  = i_data_byte[2] ? PH_EXT : PH_SIZE;
                end
            end
            PH_EXT: begin
                n_phase = PH_SIZE;
            end
            PH_SIZE: begin
                n_acc = acc_step;
                n_idx = r_idx + 1'b1;
                // size ends on a clear continuation bit or at the byte limit
                if (!i_data_byte[7] || (r_idx == IDX_LAST)) begin
                    n_rem   = acc_step;
                    n_phase = (acc_step != '0) ? PH_PAYLOAD : PH_HEADER;
                end
            end
            PH_PAYLOAD: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_phase = PH_HALTED;
            end
        endcase

        n_count = r_count;
        if ((r_at_start || td_start) && !(&r_count)) begin
            n_count = r_count + 1'b1;
        end
    end

    // result fields for this byte
    always_comb begin
        o_result.unit_start  = r_at_start || td_start;
        o_result.header_byte = is_header;
        o_result.obu_type    = n_type;
        o_result.halted      = (n_phase == PH_HALTED);
        o_result.truncated   = i_last_byte && (n_phase != PH_HEADER) && (n_phase != PH_HALTED);
        o_result.unit_count  = count_out;
    end

    if (UNIT_COUNT_WIDTH >= COUNT_OUT_W) begin : g_cnt_trunc
        assign count_out = n_count[COUNT_OUT_W-1:0];
    end else begin : g_cnt_ext
        assign count_out = {{(COUNT_OUT_W - UNIT_COUNT_WIDTH){1'b0}}, n_count};
    end

    // last byte of a stream returns the parser to its start state; count is kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_type     <= '0;
            r_acc      <= '0;
            r_idx      <= '0;
            r_rem      <= '0;
            r_at_start <= 1'b1;
            r_count    <= '0;
        end else if (i_advance) begin
            r_count    <= n_count;
            r_at_start <= i_last_byte;
            if (i_last_byte) begin
                r_phase <= PH_HEADER;
                r_type  <= '0;
                r_acc   <= '0;
                r_idx   <= '0;
                r_rem   <= '0;
            end else begin
                r_phase <= n_phase;
                r_type  <= n_type;
                r_acc   <= n_acc;
                r_idx   <= n_idx;
                r_rem   <= n_rem;
            end
        end
    end

endmodule

FILE: hdl/av1tus_out_stage.sv
// Result register with stream handshake between parser and output port.
// Depends on av1tus_pkg.
module av1tus_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  av1tus_pkg::t_result i_result,
    output logic                o_valid,
    input  logic                i_ready,
    output av1tus_pkg::t_result o_result
);
    import av1tus_pkg::*;

    logic    r_valid;
    t_result r_result;

    // refill in the same cycle the held result is taken
    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: hdl/av1_temporal_unit_splitter.sv
// Top level of the AV1 temporal unit splitter: stream ports, parser, result register.
// Depends on av1tus_pkg, av1tus_parser and av1tus_out_stage.
//
// Takes an AV1 OBU byte stream, one byte per transaction, and returns one
// result transaction per byte. The parser reads each OBU header (type, extension
// flag, has-size flag), skips an extension byte, gathers a LEB128 size of up to
// MAX_SIZE_BYTES bytes and counts the payload down. The first byte of a stream
// opens a temporal unit, and so does any later temporal-delimiter header carrying
// a size field. A header without a size field halts parsing until the stream
// ends. The byte flagged with s_axis_tlast ends the stream: its result reports
// truncation if an OBU was still open, and the parser then starts afresh while
// the unit count is kept (only reset clears it). Throughput is one byte per clock:
// a byte is parsed in the cycle it is accepted and its result lands in a single
// output register, and s_axis_tready only drops while that register holds a
// result that the sink is not taking.
module av1_temporal_unit_splitter #(
    parameter int MAX_SIZE_BYTES   = 8,
    parameter int UNIT_COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // per-byte results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [0] halted, [1] truncated, [33:2] unit_count, rest 0
    output logic [5:0]  m_axis_tuser    // [0] unit_start, [1] header_byte, [5:2] obu_type
);
    import av1tus_pkg::*;

    t_result parse_res;
    t_result out_res;
    logic    in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    av1tus_parser #(
        .MAX_SIZE_BYTES  (MAX_SIZE_BYTES),
        .UNIT_COUNT_WIDTH(UNIT_COUNT_WIDTH)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (in_xfer),
        .i_data_byte(s_axis_tdata),
        .i_last_byte(s_axis_tlast),
        .o_result   (parse_res)
    );

    av1tus_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_result(parse_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_result(out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.unit_count, out_res.truncated, out_res.halted};
    assign m_axis_tuser = {out_res.obu_type, out_res.header_byte, out_res.unit_start};

endmodule

FILE: hdl/av1tus_checker.sv
// Port-level checker for the AV1 temporal unit splitter, bound to the top level.
// Depends on av1_temporal_unit_splitter_macros.svh.
`include "av1_temporal_unit_splitter_macros.svh"

module av1tus_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [5:0]  m_axis_tuser
);

    // a held result stays put until taken
    `AV1TUS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // every accepted byte shows a result next cycle
    `AV1TUS_ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted byte produced no result")

    // an empty output register never blocks the input
    `AV1TUS_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

    // no result appears without an accepted byte
    `AV1TUS_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, (!m_axis_tvalid || m_axis_tready) && !s_axis_tvalid, !m_axis_tvalid, "result without input transaction")

endmodule

bind av1_temporal_unit_splitter av1tus_checker u_av1tus_checker (.*);
